// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the calendar clock modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tdcc_pkg.sv =====
// Package with types, constants and calendar helper functions of the calendar clock.
`default_nettype none

package tdcc_pkg;

  // Default number of display digits
  localparam int unsigned DIGIT_COUNT_DEF = 4;

  // Register reset values
  localparam logic [15:0] SECOND_PERIOD_RST = 16'd1001;
  localparam logic [15:0] DOT_HALF_MARK_RST = 16'd501;
  localparam logic [7:0]  REFRESH_PERIOD_RST = 8'd5;
  localparam logic        DOT_BLINK_RST = 1'b1;

  // Calendar reset values
  localparam logic [5:0]  SEC_RST   = 6'd18;
  localparam logic [5:0]  MIN_RST   = 6'd58;
  localparam logic [4:0]  HOUR_RST  = 5'd23;
  localparam logic [2:0]  WDAY_RST  = 3'd6;
  localparam logic [4:0]  MDAY_RST  = 5'd19;
  localparam logic [3:0]  MONTH_RST = 4'd11;
  localparam logic [11:0] YEAR_RST  = 12'd2016;
  localparam logic [8:0]  YDAY_RST  = 9'd0;

  // Calendar limits
  localparam logic [5:0]  SEC_MAX   = 6'd59;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [2:0]  WDAY_MAX  = 3'd6;
  localparam logic [3:0]  MONTH_MAX = 4'd11;
  localparam logic [11:0] YEAR_MAX  = 12'd4095;

  // Month codes that need special lengths
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;

  // Highest century in a 12-bit year
  localparam int unsigned CENTURY_LAST = 40;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SECOND_PERIOD  = 2'd0,
    REG_DOT_HALF_MARK  = 2'd1,
    REG_REFRESH_PERIOD = 2'd2,
    REG_DOT_BLINK      = 2'd3
  } reg_idx_e;

  // Configuration register contents
  typedef struct packed {
    logic [15:0] second_period;
    logic [15:0] dot_half_mark;
    logic [7:0]  refresh_period;
    logic        dot_blink_enable;
  } cfg_t;

  // Calendar fields
  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [11:0] year_full;
    logic [8:0]  day_of_year;
  } cal_t;

  // Timebase results of one step
  typedef struct packed {
    logic       second_pulse;
    logic       dot_lit;
    logic [1:0] digit_select;
    logic       draw_strobe;
  } tb_t;

  // Gregorian leap year: century years not divisible by 400 are common years
  function automatic logic leap_year(logic [11:0] y);
    logic res;
    res = (y[1:0] == 2'b00);
    for (int k = 1; k <= CENTURY_LAST; k++) begin
      if ((y == 12'(100 * k)) && ((k & 3) != 0)) begin
        res = 1'b0;
      end
    end
    return res;
  endfunction

  // Length of a month; codes above December count as 31 days
  function automatic logic [4:0] days_in_month(logic [3:0] m, logic [11:0] y);
    logic [4:0] len;
    case (m)
      MON_FEB: len = leap_year(y) ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tdcc_apb_regs.sv =====
// APB configuration registers of the calendar clock.
`default_nettype none

module tdcc_apb_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output tdcc_pkg::cfg_t     cfg_o
);

  tdcc_pkg::cfg_t   cfg_q;
  tdcc_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx   = tdcc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.second_period    <= tdcc_pkg::SECOND_PERIOD_RST;
      cfg_q.dot_half_mark    <= tdcc_pkg::DOT_HALF_MARK_RST;
      cfg_q.refresh_period   <= tdcc_pkg::REFRESH_PERIOD_RST;
      cfg_q.dot_blink_enable <= tdcc_pkg::DOT_BLINK_RST;
    end else if (wr_en) begin
      case (idx)
        tdcc_pkg::REG_SECOND_PERIOD:  cfg_q.second_period    <= pwdata[15:0];
        tdcc_pkg::REG_DOT_HALF_MARK:  cfg_q.dot_half_mark    <= pwdata[15:0];
        tdcc_pkg::REG_REFRESH_PERIOD: cfg_q.refresh_period   <= pwdata[7:0];
        tdcc_pkg::REG_DOT_BLINK:      cfg_q.dot_blink_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (idx)
      tdcc_pkg::REG_SECOND_PERIOD:  prdata = {16'd0, cfg_q.second_period};
      tdcc_pkg::REG_DOT_HALF_MARK:  prdata = {16'd0, cfg_q.dot_half_mark};
      tdcc_pkg::REG_REFRESH_PERIOD: prdata = {24'd0, cfg_q.refresh_period};
      tdcc_pkg::REG_DOT_BLINK:      prdata = {31'd0, cfg_q.dot_blink_enable};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/tdcc_timebase.sv =====
// Millisecond prescaler, blink dot and display refresh divider.
`default_nettype none

`include "assert_macros.svh"

module tdcc_timebase #(
  parameter int unsigned DIGIT_COUNT = tdcc_pkg::DIGIT_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  tdcc_pkg::cfg_t cfg_i,
  output tdcc_pkg::tb_t  tb_o
);

  localparam int unsigned IDX_W = (DIGIT_COUNT > 4) ? 3 : 2;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGIT_COUNT - 1);

  logic [15:0]      tc_q, tc_d, tc_inc;
  logic [7:0]       rc_q, rc_d, rc_inc;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             dot_q, dot_d;
  logic             pulse, strobe;

  assign tc_inc = tc_q + 16'd1;
  assign rc_inc = rc_q + 8'd1;

  // Advance the counters on a tick
  always_comb begin
    tc_d   = tc_q;
    rc_d   = rc_q;
    idx_d  = idx_q;
    dot_d  = dot_q;
    pulse  = 1'b0;
    strobe = 1'b0;
    if (step_i) begin
      rc_d = rc_inc;
      if (rc_inc >= cfg_i.refresh_period) begin
        strobe = 1'b1;
        rc_d   = 8'd0;
        idx_d  = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);
      end
      tc_d = tc_inc;
      if (tc_inc == cfg_i.dot_half_mark) begin
        dot_d = 1'b1;
      end
      if (tc_inc >= cfg_i.second_period) begin
        tc_d  = 16'd0;
        pulse = 1'b1;
        if (cfg_i.dot_blink_enable) begin
          dot_d = 1'b0;
        end
      end
    end
  end

  // Hold the timebase state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q  <= 16'd0;
      rc_q  <= 8'd0;
      idx_q <= '0;
      dot_q <= 1'b0;
    end else begin
      tc_q  <= tc_d;
      rc_q  <= rc_d;
      idx_q <= idx_d;
      dot_q <= dot_d;
    end
  end

  assign tb_o.second_pulse = pulse;
  assign tb_o.dot_lit      = dot_d;
  assign tb_o.digit_select = idx_d[1:0];
  assign tb_o.draw_strobe  = strobe;

  `ASSERT_NEXT(a_strobe_clears, strobe, rc_q == 8'd0, "refresh count not cleared after strobe")
  `ASSERT_NEXT(a_pulse_clears, pulse, tc_q == 16'd0, "tick count not cleared after second pulse")
  `ASSERT_ALWAYS(a_idx_range, idx_q <= IDX_LAST, "digit index past last digit")

endmodule

`default_nettype wire

// ===== rtl/tdcc_calendar.sv =====
// Gregorian calendar registers advanced by one second per pulse.
`default_nettype none

`include "assert_macros.svh"

module tdcc_calendar (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  output tdcc_pkg::cal_t cal_o
);

  tdcc_pkg::cal_t cal_q, cal_d;
  logic [5:0]  sec_inc, min_inc;
  logic [4:0]  hour_inc, mday_inc, dim;
  logic [2:0]  wday_inc;
  logic [3:0]  mon_inc;
  logic [8:0]  yday_inc;

  assign sec_inc  = cal_q.seconds + 6'd1;
  assign min_inc  = cal_q.minutes + 6'd1;
  assign hour_inc = cal_q.hours + 5'd1;
  assign wday_inc = cal_q.weekday + 3'd1;
  assign mday_inc = cal_q.day_of_month + 5'd1;
  assign mon_inc  = cal_q.month_index + 4'd1;
  assign yday_inc = cal_q.day_of_year + 9'd1;
  assign dim      = tdcc_pkg::days_in_month(cal_q.month_index, cal_q.year_full);

  // Ripple the carry from seconds up to the year
  always_comb begin
    cal_d = cal_q;
    if (advance_i) begin
      cal_d.seconds = sec_inc;
      if (sec_inc > tdcc_pkg::SEC_MAX) begin
        cal_d.seconds = 6'd0;
        cal_d.minutes = min_inc;
        if (min_inc > tdcc_pkg::MIN_MAX) begin
          cal_d.minutes = 6'd0;
          cal_d.hours   = hour_inc;
          if (hour_inc > tdcc_pkg::HOUR_MAX) begin
            cal_d.hours        = 5'd0;
            cal_d.day_of_year  = yday_inc;
            cal_d.weekday      = (wday_inc > tdcc_pkg::WDAY_MAX) ? 3'd0 : wday_inc;
            cal_d.day_of_month = mday_inc;
            if ((mday_inc > dim) || (mday_inc == 5'd0)) begin
              cal_d.day_of_month = 5'd1;
              cal_d.month_index  = mon_inc;
              if (mon_inc > tdcc_pkg::MONTH_MAX) begin
                cal_d.month_index = 4'd0;
                cal_d.day_of_year = 9'd0;
                if (cal_q.year_full < tdcc_pkg::YEAR_MAX) begin
                  cal_d.year_full = cal_q.year_full + 12'd1;
                end
              end
            end
          end
        end
      end
    end
  end

  // Hold the calendar
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.seconds      <= tdcc_pkg::SEC_RST;
      cal_q.minutes      <= tdcc_pkg::MIN_RST;
      cal_q.hours        <= tdcc_pkg::HOUR_RST;
      cal_q.weekday      <= tdcc_pkg::WDAY_RST;
      cal_q.day_of_month <= tdcc_pkg::MDAY_RST;
      cal_q.month_index  <= tdcc_pkg::MONTH_RST;
      cal_q.year_full    <= tdcc_pkg::YEAR_RST;
      cal_q.day_of_year  <= tdcc_pkg::YDAY_RST;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_d;

  `ASSERT_ALWAYS(a_sec_range, cal_q.seconds <= tdcc_pkg::SEC_MAX, "seconds out of range")
  `ASSERT_ALWAYS(a_min_range, cal_q.minutes <= tdcc_pkg::MIN_MAX, "minutes out of range")
  `ASSERT_NEXT(a_sec_moves, advance_i, cal_q.seconds != $past(cal_q.seconds), "second did not advance")

endmodule

`default_nettype wire

// ===== rtl/tick_driven_calendar_clock.sv =====
// Top level of the tick-driven calendar clock with output word register.
//
//  channel   dir  word                        accepted when
//  s_axis    in   tick in tdata[0]            s_axis_tvalid & s_axis_tready
//  m_axis    out  calendar and display state  m_axis_tvalid & m_axis_tready
//  apb       in   4 config registers          psel & penable & pwrite
//
// A new word is accepted every cycle while the output register is not stalled.
// The result appears in the output register on the cycle after acceptance.
// The counter and calendar update between the state and output registers.
// A stalled output register holds its word and blocks input until taken.
// Reset restores the calendar start time and the register defaults.
`default_nettype none

`include "assert_macros.svh"

module tick_driven_calendar_clock #(
  parameter int unsigned DIGIT_COUNT = tdcc_pkg::DIGIT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [0] tick, [7:1] zero
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // tdata: [5:0] seconds, [11:6] minutes, [16:12] hours, [19:17] weekday,
  // [24:20] day_of_month, [28:25] month_index, [40:29] year_full,
  // [49:41] day_of_year, [50] second_pulse, [51] dot_lit,
  // [53:52] digit_select, [54] draw_strobe, [55] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tdcc_pkg::cfg_t cfg;
  tdcc_pkg::cal_t cal;
  tdcc_pkg::tb_t  tb;
  logic           accept, step;
  logic           out_valid_q, out_valid_d;
  logic [55:0]    out_data_q;

  assign pready        = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign step          = accept & s_axis_tdata[0];

  tdcc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  tdcc_timebase #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_timebase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .tb_o   (tb)
  );

  tdcc_calendar u_calendar (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (tb.second_pulse),
    .cal_o     (cal)
  );

  // Load a word on accept, drop valid once taken
  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {1'b0, tb.draw_strobe, tb.digit_select, tb.dot_lit, tb.second_pulse,
                     cal.day_of_year, cal.year_full, cal.month_index, cal.day_of_month,
                     cal.weekday, cal.hours, cal.minutes, cal.seconds};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_ALWAYS(a_stall_blocks, !(out_valid_q && !m_axis_tready && accept), "input taken while output stalled")
  `ASSERT_NEXT(a_accept_valid, accept, out_valid_q, "accepted word not presented")
  `ASSERT_NEXT(a_idle_no_pulse, accept && !s_axis_tdata[0], !out_data_q[50] && !out_data_q[54], "idle tick produced an event")

endmodule

`default_nettype wire

// ===== tb/sv/tb_tick_driven_calendar_clock.sv =====
// Testbench for the tick-driven calendar clock: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module tb_tick_driven_calendar_clock;

  localparam int unsigned DIGITS = tdcc_pkg::DIGIT_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int NUM_FIELDS = 13;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS = 158;

  // Output word layout, lowest field first; the last entry is the zero pad bit
  localparam int FIELD_LSB [NUM_FIELDS] = '{0, 6, 12, 17, 20, 25, 29, 41, 50, 51, 52, 54, 55};
  localparam int FIELD_W [NUM_FIELDS] = '{6, 6, 5, 3, 5, 4, 12, 9, 1, 1, 2, 1, 1};
  string field_label [NUM_FIELDS] = '{"seconds", "minutes", "hours", "weekday",
    "day_of_month", "month_index", "year_full", "day_of_year", "second_pulse",
    "dot_lit", "digit_select", "draw_strobe", "pad"};

  // Month lengths in a common year, January first
  localparam logic [4:0] MONTH_DAYS [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted clock state and register contents
  tdcc_pkg::cfg_t clk_cfg;
  tdcc_pkg::cal_t cal;
  logic [15:0] tick_cnt;
  logic [7:0]  refresh_cnt;
  int unsigned digit_idx;
  logic        dot;

  logic [55:0] expected_words [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_cycles;

  tick_driven_calendar_clock uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(logic [11:0] y);
    int r;
    r = int'(y) % 400;
    return (y[1:0] == 2'b00) && (r != 100) && (r != 200) && (r != 300);
  endfunction

  function automatic logic [4:0] month_length(logic [3:0] m, logic [11:0] y);
    if (m > tdcc_pkg::MONTH_MAX) return 5'd31;
    if (m == tdcc_pkg::MON_FEB && is_leap(y)) return 5'd29;
    return MONTH_DAYS[m];
  endfunction

  // Advance the calendar by one second, carrying through to the year
  function automatic void bump_second();
    cal.seconds = cal.seconds + 6'd1;
    if (cal.seconds <= tdcc_pkg::SEC_MAX) return;
    cal.seconds = '0;
    cal.minutes = cal.minutes + 6'd1;
    if (cal.minutes <= tdcc_pkg::MIN_MAX) return;
    cal.minutes = '0;
    cal.hours = cal.hours + 5'd1;
    if (cal.hours <= tdcc_pkg::HOUR_MAX) return;
    cal.hours = '0;
    cal.day_of_year = cal.day_of_year + 9'd1;
    cal.weekday = cal.weekday + 3'd1;
    if (cal.weekday > tdcc_pkg::WDAY_MAX) cal.weekday = '0;
    cal.day_of_month = cal.day_of_month + 5'd1;
    if (cal.day_of_month > month_length(cal.month_index, cal.year_full) ||
        cal.day_of_month == 5'd0) begin
      cal.day_of_month = 5'd1;
      cal.month_index = cal.month_index + 4'd1;
      if (cal.month_index > tdcc_pkg::MONTH_MAX) begin
        cal.month_index = '0;
        cal.day_of_year = '0;
        if (cal.year_full < tdcc_pkg::YEAR_MAX) cal.year_full = cal.year_full + 12'd1;
      end
    end
  endfunction

  // Apply one tick word to the predicted state and build the output word
  function automatic logic [55:0] next_clock_word(input logic tick);
    logic pulse;
    logic strobe;
    pulse = 1'b0;
    strobe = 1'b0;
    if (tick) begin
      refresh_cnt = refresh_cnt + 8'd1;
      if (refresh_cnt >= clk_cfg.refresh_period) begin
        digit_idx = (digit_idx >= DIGITS - 1) ? 0 : digit_idx + 1;
        strobe = 1'b1;
        refresh_cnt = '0;
      end
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt == clk_cfg.dot_half_mark) dot = 1'b1;
      if (tick_cnt >= clk_cfg.second_period) begin
        tick_cnt = '0;
        pulse = 1'b1;
        if (clk_cfg.dot_blink_enable) dot = 1'b0;
        bump_second();
      end
    end
    return {1'b0, strobe, digit_idx[1:0], dot, pulse, cal.day_of_year, cal.year_full,
            cal.month_index, cal.day_of_month, cal.weekday, cal.hours, cal.minutes,
            cal.seconds};
  endfunction

  function automatic void reset_clock_model();
    clk_cfg.second_period = tdcc_pkg::SECOND_PERIOD_RST;
    clk_cfg.dot_half_mark = tdcc_pkg::DOT_HALF_MARK_RST;
    clk_cfg.refresh_period = tdcc_pkg::REFRESH_PERIOD_RST;
    clk_cfg.dot_blink_enable = tdcc_pkg::DOT_BLINK_RST;
    cal.seconds = tdcc_pkg::SEC_RST;
    cal.minutes = tdcc_pkg::MIN_RST;
    cal.hours = tdcc_pkg::HOUR_RST;
    cal.weekday = tdcc_pkg::WDAY_RST;
    cal.day_of_month = tdcc_pkg::MDAY_RST;
    cal.month_index = tdcc_pkg::MONTH_RST;
    cal.year_full = tdcc_pkg::YEAR_RST;
    cal.day_of_year = tdcc_pkg::YDAY_RST;
    tick_cnt = '0;
    refresh_cnt = '0;
    digit_idx = 0;
    dot = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: check each output word, predict each accepted tick word
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    logic [55:0] want;
    logic [63:0] got_f;
    logic [63:0] want_f;
    bit          bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        $display("%0t: output word expected none got %h", $time, m_axis_tdata);
      end else begin
        want = expected_words.pop_front();
        bad = 1'b0;
        for (int k = 0; k < NUM_FIELDS; k++) begin
          got_f = (64'(m_axis_tdata) >> FIELD_LSB[k]) & ((64'd1 << FIELD_W[k]) - 1);
          want_f = (64'(want) >> FIELD_LSB[k]) & ((64'd1 << FIELD_W[k]) - 1);
          if (got_f !== want_f) begin
            bad = 1'b1;
            $display("%0t: %s expected %0d got %0d", $time, field_label[k], want_f, got_f);
          end
        end
        if (bad) mismatch_count++;
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_words.push_back(next_clock_word(s_axis_tdata[0]));
  end

  // Hold the run to a cycle budget
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: random stall bursts plus a long hold-off on request
  initial begin : rx_side
    int unsigned stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 11);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one tick word, with an optional gap first, and wait for acceptance
  task automatic send_tick(input logic tick);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, tick};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Setup and access phases, then idle before the next transfer
  task automatic apb_write(input tdcc_pkg::reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tdcc_pkg::REG_SECOND_PERIOD:  clk_cfg.second_period = value[15:0];
      tdcc_pkg::REG_DOT_HALF_MARK:  clk_cfg.dot_half_mark = value[15:0];
      tdcc_pkg::REG_REFRESH_PERIOD: clk_cfg.refresh_period = value[7:0];
      tdcc_pkg::REG_DOT_BLINK:      clk_cfg.dot_blink_enable = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_clock_config(input logic [15:0] sp, input logic [15:0] dm,
                                  input logic [7:0] rp, input logic be);
    wait_until_idle();
    apb_write(tdcc_pkg::REG_SECOND_PERIOD, {16'd0, sp});
    apb_write(tdcc_pkg::REG_DOT_HALF_MARK, {16'd0, dm});
    apb_write(tdcc_pkg::REG_REFRESH_PERIOD, {24'd0, rp});
    apb_write(tdcc_pkg::REG_DOT_BLINK, {31'd0, be});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers right after reset, idle and real ticks
  task automatic test_reset_state();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Periods of zero and one fire on every tick
  task automatic test_every_tick_periods();
    set_clock_config(16'd0, 16'd1, 8'd0, 1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    set_clock_config(16'd1, 16'd1, 8'd1, 1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Dot mark landing on the second pulse, with and without blinking, and a mark past the period
  task automatic test_dot_on_pulse();
    set_clock_config(16'd3, 16'd3, 8'd2, 1'b1);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    wait_until_idle();
    apb_write(tdcc_pkg::REG_DOT_BLINK, 32'd0);
    repeat (3) send_tick(1'b1);
    set_clock_config(16'd3, 16'hFFFF, 8'd2, 1'b1);
    repeat (3) send_tick(1'b1);
  endtask

  // Register writes with junk above each register's width
  task automatic test_wide_writes();
    wait_until_idle();
    apb_write(tdcc_pkg::REG_SECOND_PERIOD, 32'hABCD_0002);
    apb_write(tdcc_pkg::REG_DOT_HALF_MARK, 32'hFFFF_0001);
    apb_write(tdcc_pkg::REG_REFRESH_PERIOD, 32'h1234_5602);
    apb_write(tdcc_pkg::REG_DOT_BLINK, 32'hFFFF_FFFE);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_until_idle();
    apb_write(tdcc_pkg::REG_DOT_BLINK, 32'h8000_0001);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Random ticks over a series of register settings; the first two phases
  // pulse every tick so the calendar rolls over midnight
  task automatic test_random_ticks();
    logic [15:0] sp;
    logic [15:0] dm;
    logic [7:0]  rp;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 2) begin
        sp = 16'(1 - ph);
      end else begin
        case ($urandom_range(0, 4))
          0: sp = 16'($urandom_range(0, 1));
          1, 2: sp = 16'($urandom_range(2, 6));
          3: sp = 16'($urandom_range(7, 40));
          default: sp = 16'hFFFF;
        endcase
      end
      dm = 16'($urandom_range(0, int'(sp) + 2));
      case ($urandom_range(0, 3))
        0: rp = 8'($urandom_range(0, 1));
        1: rp = 8'hFF;
        default: rp = 8'($urandom_range(2, 6));
      endcase
      set_clock_config(sp, dm, rp, 1'($urandom_range(0, 1)));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 2 && i == 60) rx_hold_cycles = 60;
        send_tick($urandom_range(0, 6) != 0);
      end
    end
  endtask

  // Longest periods at full rate with no idling on either side
  task automatic test_longest_period();
    set_clock_config(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (65) send_tick(1'b1);
  endtask

  initial begin
    reset_clock_model();
    mismatch_count = 0;
    cycle_count = 0;
    rx_hold_cycles = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_every_tick_periods();
    test_dot_on_pulse();
    test_wide_writes();
    test_random_ticks();
    test_longest_period();

    wait_until_idle();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
